FILE: hw/rtl/tqod_pkg.sv
package tqod_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int PLANE_BITS  = SQ_BITS + 1;
    localparam int RATIO_BITS  = 4;
    localparam int COUNT_BITS  = 3;
    localparam int SCALED_BITS = PLANE_BITS + RATIO_BITS;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLAT_RATIO    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_LEVEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_LIMIT   = 2'd2;

    localparam logic [RATIO_BITS-1:0] FLAT_RATIO_RST    = 4'd3;
    localparam logic [COUNT_BITS-1:0] CONFIRM_LEVEL_RST = 3'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT_RST   = 3'd4;

    // quadrants: nearest axis of (x, y)
    localparam logic [1:0] QUAD_POS_X = 2'd0;
    localparam logic [1:0] QUAD_POS_Y = 2'd1;
    localparam logic [1:0] QUAD_NEG_X = 2'd2;
    localparam logic [1:0] QUAD_NEG_Y = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic       sample_tilted;
        logic [1:0] candidate;
    } result_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] flat_ratio;
        logic [COUNT_BITS-1:0] confirm_level;
        logic [COUNT_BITS-1:0] count_limit;
    } cfg_t;

    // stage one output: squared energies and quadrant
    typedef struct packed {
        logic [PLANE_BITS-1:0] inplane;
        logic [SQ_BITS-1:0]    z_sq;
        logic [1:0]            quadrant;
    } energy_t;

endpackage

FILE: hw/rtl/tilt_quadrant_orientation_debounce.sv
// Path from input request accept to result valid runs through the input, square and result regs.
// Throughput: one sample per cycle; all stages stall together when the result is held.
// The inplane * flat_ratio product after the square register sets the critical path.
// Reset (aresetn, synchronous, active low): rotation, candidate and repeat count
// clear to 0, registers return to flat_ratio 3, confirm_level 3, count_limit 4.
module tilt_quadrant_orientation_debounce (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tqod_pkg::sample_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tqod_pkg::result_t                    m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tqod_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tqod_pkg::RATIO_BITS-1:0]      cfg_data
);
    import tqod_pkg::*;

    logic    advance;
    logic    in_valid_reg;
    sample_t in_data_reg;
    logic    energy_valid_reg;
    energy_t energy;
    logic    out_valid_reg;
    cfg_t    cfg_reg;

    // whole pipeline moves when the result register is free or being drained
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance;
    assign m_valid   = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            energy_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else if (advance) begin
            in_valid_reg     <= s_valid;
            energy_valid_reg <= in_valid_reg;
            out_valid_reg    <= energy_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flat_ratio    <= FLAT_RATIO_RST;
            cfg_reg.confirm_level <= CONFIRM_LEVEL_RST;
            cfg_reg.count_limit   <= COUNT_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FLAT_RATIO:    cfg_reg.flat_ratio    <= cfg_data;
                CFG_CONFIRM_LEVEL: cfg_reg.confirm_level <= cfg_data[COUNT_BITS-1:0];
                CFG_COUNT_LIMIT:   cfg_reg.count_limit   <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    tqod_square u_square (
        .aclk       (aclk),
        .advance    (advance),
        .sample     (in_data_reg),
        .energy_reg (energy)
    );

    tqod_classify u_classify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .energy_valid (energy_valid_reg),
        .energy       (energy),
        .cfg          (cfg_reg),
        .result_reg   (m_data)
    );

endmodule

FILE: hw/rtl/tqod_square.sv
module tqod_square (
    input  logic             aclk,
    input  logic             advance,
    input  tqod_pkg::sample_t sample,
    output tqod_pkg::energy_t energy_reg
);
    import tqod_pkg::*;

    logic [SAMPLE_BITS-1:0] mag_x;
    logic [SAMPLE_BITS-1:0] mag_y;
    logic [SAMPLE_BITS-1:0] mag_z;
    logic                   neg_x;
    logic                   neg_y;
    logic [SQ_BITS-1:0]     sq_x;
    logic [SQ_BITS-1:0]     sq_y;
    logic [1:0]             quad;
    energy_t                energy_next;

    assign neg_x = sample.accel_x[SAMPLE_BITS-1];
    assign neg_y = sample.accel_y[SAMPLE_BITS-1];
    // most negative value maps to 2^(N-1), which still fits unsigned
    assign mag_x = neg_x ? SAMPLE_BITS'(-sample.accel_x) : sample.accel_x;
    assign mag_y = neg_y ? SAMPLE_BITS'(-sample.accel_y) : sample.accel_y;
    assign mag_z = sample.accel_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample.accel_z)
                                                 : sample.accel_z;

    assign sq_x = SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
    assign sq_y = SQ_BITS'(mag_y) * SQ_BITS'(mag_y);

    // diagonal ties round away from zero: -x wins, else the y axis
    always_comb begin
        if (mag_x > mag_y) begin
            quad = neg_x ? QUAD_NEG_X : QUAD_POS_X;
        end else if (mag_x == '0 && mag_y == '0) begin
            quad = QUAD_POS_X;
        end else if (mag_x == mag_y && neg_x) begin
            quad = QUAD_NEG_X;
        end else begin
            quad = neg_y ? QUAD_NEG_Y : QUAD_POS_Y;
        end
    end

    always_comb begin
        energy_next.inplane  = PLANE_BITS'(sq_x) + PLANE_BITS'(sq_y);
        energy_next.z_sq     = SQ_BITS'(mag_z) * SQ_BITS'(mag_z);
        energy_next.quadrant = quad;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            energy_reg <= energy_next;
        end
    end

endmodule

FILE: hw/rtl/tqod_classify.sv
module tqod_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              energy_valid,
    input  tqod_pkg::energy_t energy,
    input  tqod_pkg::cfg_t    cfg,
    output tqod_pkg::result_t result_reg
);
    import tqod_pkg::*;

    logic [1:0]             rotation_reg;
    logic [1:0]             rotation_next;
    logic [1:0]             candidate_reg;
    logic [1:0]             candidate_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [RATIO_BITS-1:0]  divisor;
    logic [SCALED_BITS-1:0] scaled_plane;
    logic                   tilted;
    result_t                result_next;

    // inplane > floor(z^2 / d)  <=>  inplane * d > z^2
    assign divisor      = (cfg.flat_ratio == '0) ? RATIO_BITS'(1) : cfg.flat_ratio;
    assign scaled_plane = SCALED_BITS'(energy.inplane) * SCALED_BITS'(divisor);
    assign tilted       = scaled_plane > SCALED_BITS'(energy.z_sq);

    always_comb begin
        rotation_next  = rotation_reg;
        candidate_next = candidate_reg;
        count_next     = count_reg;
        if (tilted) begin
            if (energy.quadrant == candidate_reg) begin
                if (count_reg < cfg.count_limit) begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                if (count_next >= cfg.confirm_level) begin
                    rotation_next = energy.quadrant;
                end
            end else begin
                candidate_next = energy.quadrant;
                count_next     = '0;
            end
        end
        result_next.rotation      = rotation_next;
        result_next.sample_tilted = tilted;
        result_next.candidate     = candidate_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg  <= '0;
            candidate_reg <= '0;
            count_reg     <= '0;
        end else if (advance && energy_valid) begin
            rotation_reg  <= rotation_next;
            candidate_reg <= candidate_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && energy_valid) begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: tb/tb_tilt_quadrant_orientation_debounce.sv
`timescale 1ns / 100ps

module tb_tilt_quadrant_orientation_debounce;
    import tqod_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 180;

    class orientation_scoreboard;
        result_t expected_q[$];
        cfg_t    regs;
        logic [1:0] rotation_st;
        logic [1:0] candidate_st;
        logic [2:0] repeat_st;
        int errors;
        int n_samples;
        int n_tilted;
        int n_results;
        int n_writes;

        function new();
            regs.flat_ratio    = FLAT_RATIO_RST;
            regs.confirm_level = CONFIRM_LEVEL_RST;
            regs.count_limit   = COUNT_LIMIT_RST;
            rotation_st  = QUAD_POS_X;
            candidate_st = QUAD_POS_X;
            repeat_st    = '0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [RATIO_BITS-1:0] val);
            n_writes++;
            case (idx)
                CFG_FLAT_RATIO:    regs.flat_ratio = val;
                CFG_CONFIRM_LEVEL: regs.confirm_level = val[COUNT_BITS-1:0];
                CFG_COUNT_LIMIT:   regs.count_limit = val[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_BITS:0] magnitude(logic [SAMPLE_BITS-1:0] v);
            return v[SAMPLE_BITS-1] ? (17'd65536 - {1'b0, v}) : {1'b0, v};
        endfunction

        function void note_sample(sample_t smp);
            logic [SAMPLE_BITS:0] mx, my, mz;
            logic [33:0] inplane, z_sq, z_part;
            logic [RATIO_BITS-1:0] dv;
            logic nx, ny, tilted;
            logic [1:0] quad;
            result_t r;
            mx = magnitude(smp.accel_x);
            my = magnitude(smp.accel_y);
            mz = magnitude(smp.accel_z);
            nx = smp.accel_x[SAMPLE_BITS-1];
            ny = smp.accel_y[SAMPLE_BITS-1];
            dv = (regs.flat_ratio == 0) ? 4'd1 : regs.flat_ratio;
            inplane = 34'(mx) * 34'(mx) + 34'(my) * 34'(my);
            z_sq    = 34'(mz) * 34'(mz);
            z_part  = z_sq / 34'(dv);
            tilted  = inplane > z_part;

            if (mx == 0 && my == 0)
                quad = QUAD_POS_X;
            else if (mx > my)
                quad = nx ? QUAD_NEG_X : QUAD_POS_X;
            else if (my > mx)
                quad = ny ? QUAD_NEG_Y : QUAD_POS_Y;
            else if (nx)
                quad = QUAD_NEG_X;  // diagonal ties round away from zero
            else
                quad = ny ? QUAD_NEG_Y : QUAD_POS_Y;

            if (tilted) begin
                n_tilted++;
                if (quad == candidate_st) begin
                    // a count above a lowered limit is held, not cut back
                    if (repeat_st < regs.count_limit)
                        repeat_st = repeat_st + 3'd1;
                    if (repeat_st >= regs.confirm_level)
                        rotation_st = quad;
                end else begin
                    candidate_st = quad;
                    repeat_st = '0;
                end
            end

            r.rotation      = rotation_st;
            r.sample_tilted = tilted;
            r.candidate     = candidate_st;
            expected_q.push_back(r);
            n_samples++;
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result rot=%0d tilt=%0d cand=%0d with no request pending",
                                 got.rotation, got.sample_tilted, got.candidate));
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            if (got.rotation !== want.rotation)
                report($sformatf("result %0d rotation %0d, want %0d",
                                 n_results, got.rotation, want.rotation));
            if (got.sample_tilted !== want.sample_tilted)
                report($sformatf("result %0d sample_tilted %0d, want %0d",
                                 n_results, got.sample_tilted, want.sample_tilted));
            if (got.candidate !== want.candidate)
                report($sformatf("result %0d candidate %0d, want %0d",
                                 n_results, got.candidate, want.candidate));
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sample_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    result_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [RATIO_BITS-1:0] cfg_data = '0;

    orientation_scoreboard sb;
    bit steady = 1'b0;
    bit long_hold = 1'b0;
    int n_settings = 0;

    tilt_quadrant_orientation_debounce dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        #4000000;
        $display("timeout waiting for the block");
        $display("tb_tilt_quadrant_orientation_debounce: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_sample(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    initial begin : receiver
        bit level;
        int run;
        level = 1'b0;
        run = 0;
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                if (steady) begin
                    level = 1'b1;
                    run = 0;
                end else begin
                    if (run == 0) begin
                        level = ~level;
                        run = level ? $urandom_range(1, 12) : pick_gap() + 1;
                    end
                    run--;
                end
                m_ready <= level;
                @(posedge aclk);
            end
        end
    end

    function sample_t mk(int x, int y, int z);
        sample_t s;
        s.accel_x = 16'(x);
        s.accel_y = 16'(y);
        s.accel_z = 16'(z);
        return s;
    endfunction

    // tilted sample near one axis; tie puts it on the diagonal
    function sample_t tilted_sample(logic [1:0] quad, bit tie);
        int major, minor, z;
        major = $urandom_range(1, 32767);
        if ($urandom_range(0, 15) == 0)
            major = 32767;
        minor = tie ? major : $urandom_range(0, major - 1);
        if ($urandom_range(0, 1))
            minor = -minor;
        z = $urandom_range(0, major - 1);
        if ($urandom_range(0, 1))
            z = -z;
        case (quad)
            QUAD_POS_X: return mk(major, minor, z);
            QUAD_POS_Y: return mk(minor, major, z);
            QUAD_NEG_X: return mk(-major, minor, z);
            default:    return mk(minor, -major, z);
        endcase
    endfunction

    function sample_t flat_sample();
        int z;
        z = $urandom_range(20000, 32768);
        if ($urandom_range(0, 1))
            z = -z;
        return mk($urandom_range(0, 100) - 50, $urandom_range(0, 100) - 50, z);
    endfunction

    task offer(sample_t smp);
        int gap;
        s_data  <= smp;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task write_regs(logic [3:0] ratio, logic [3:0] confirm, logic [3:0] limit);
        logic [CFG_IDX_BITS-1:0] idx[4];
        logic [RATIO_BITS-1:0] val[4];
        idx = '{CFG_COUNT_LIMIT, CFG_UNUSED, CFG_FLAT_RATIO, CFG_CONFIRM_LEVEL};
        val = '{limit, 4'($urandom), ratio, confirm};
        for (int i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task run_random(int n_items);
        int sent, pause_at, r, len;
        logic [1:0] quad;
        sent = 0;
        pause_at = $urandom_range(n_items / 4, n_items - 1);
        while (sent < n_items) begin
            if (sent >= pause_at) begin
                wait_idle();
                pause_at = n_items;
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                quad = 2'($urandom);
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        offer(flat_sample());
                    else
                        offer(tilted_sample(quad, 1'b0));
                end
                sent += len;
            end else begin
                case (r % 4)
                    0: offer(mk($urandom, $urandom, $urandom));
                    1: offer(flat_sample());
                    2: offer(tilted_sample(2'($urandom), 1'b1));
                    default: offer(mk(0, 0, $urandom));
                endcase
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [3:0] ratio, confirm, limit;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: gate boundary, every axis, diagonal ties, commits
        offer(mk(0, 0, 0));
        offer(mk(0, 0, -32768));
        offer(mk(1, 0, 2));
        offer(mk(1, 0, 1));
        offer(mk(32767, 0, 0));
        offer(mk(32767, 100, -5));
        offer(mk(0, 32767, 0));
        offer(mk(100, 200, 0));
        offer(mk(-5, 32767, 32767));
        offer(mk(3, 9, -1));
        offer(mk(-32768, 0, 0));
        offer(mk(-100, 100, 0));
        offer(mk(-100, -100, 0));
        offer(mk(-32768, -32768, -32768));
        offer(mk(0, -32768, 0));
        offer(mk(100, -100, 0));
        offer(mk(100, 100, 0));
        offer(mk(32767, 32767, 32767));
        offer(mk(101, 100, 7));

        // zero ratio acts as one; zero confirm still needs a repeat
        wait_idle();
        write_regs(4'd0, 4'd0, 4'd7);
        offer(mk(0, -1, 1));
        offer(mk(0, -2, 1));
        offer(mk(5, -9, 0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin ratio = 4'd3;  confirm = 4'd3;  limit = 4'd4; end
                1: begin ratio = 4'd15; confirm = 4'd7;  limit = 4'd7; end
                2: begin ratio = 4'd1;  confirm = 4'd0;  limit = 4'd0; end
                3: begin ratio = 4'd0;  confirm = 4'd9;  limit = 4'd2; end
                7: begin ratio = 4'd8;  confirm = 4'd2;  limit = 4'd5; end
                default: begin
                    ratio   = 4'($urandom);
                    confirm = 4'($urandom);
                    limit   = 4'($urandom);
                end
            endcase
            write_regs(ratio, confirm, limit);
            steady = (p == 4);
            long_hold = (p == 5);
            run_random(PHASE_ITEMS);
            steady = 1'b0;
        end

        wait_idle();
        sb.close_out();
        $display("covered %0d samples (%0d tilted), %0d results checked",
                 sb.n_samples, sb.n_tilted, sb.n_results);
        $display("across %0d register settings, %0d register writes", n_settings, sb.n_writes);
        if (sb.errors == 0)
            $display("tb_tilt_quadrant_orientation_debounce: done, clean");
        else
            $display("tb_tilt_quadrant_orientation_debounce: done, errors");
        $finish;
    end

endmodule
